FILE: rtl/core/periodic_probe_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Periodic probe scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_PROBE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_PROBE_SCHEDULER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// Periodic probe scheduler package
// Shared constants, operation and status codes, and due-time arithmetic.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int STRATEGIES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SCHEDULES_DEF   = 8;

  localparam logic [3:0]  BUDGET_RESET   = 4'd5;
  localparam logic [16:0] UNTIMED_PERIOD = 17'h1FFFF;
  localparam logic [31:0] TIME_MAX       = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ADD_STRAT = 3'd1;
  localparam logic [2:0] OP_DEL_STRAT = 3'd2;
  localparam logic [2:0] OP_ADD_OBJ   = 3'd3;
  localparam logic [2:0] OP_DEL_OBJ   = 3'd4;
  localparam logic [2:0] OP_ADD_SCHED = 3'd5;
  localparam logic [2:0] OP_MOD_SCHED = 3'd6;
  localparam logic [2:0] OP_DEL_SCHED = 3'd7;

  localparam logic [3:0] STAT_OK           = 4'd0;
  localparam logic [3:0] STAT_STRAT_EXISTS = 4'd1;
  localparam logic [3:0] STAT_STRAT_MISS   = 4'd2;
  localparam logic [3:0] STAT_OBJ_EXISTS   = 4'd3;
  localparam logic [3:0] STAT_OBJ_MISS     = 4'd4;
  localparam logic [3:0] STAT_SCHED_MISS   = 4'd5;
  localparam logic [3:0] STAT_SCHED_EXISTS = 4'd6;
  localparam logic [3:0] STAT_QUEUE_FULL   = 4'd7;
  localparam logic [3:0] STAT_SCHED_FULL   = 4'd8;

  // now plus period, saturating; an untimed period means never
  function automatic logic [31:0] due_from_now(logic [16:0] per, logic [31:0] now);
    logic [32:0] sum;
    sum = {1'b0, now} + 33'(per);
    if (per == UNTIMED_PERIOD || sum[32]) begin
      return TIME_MAX;
    end
    return sum[31:0];
  endfunction

endpackage

FILE: rtl/core/pps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/periodic_probe_scheduler_top.sv
// Throughput: one item at a time; the next item is taken once the last result
//   sits in the output register. Reset: rst_ni is asynchronous, active low; it
//   empties all slots, sets time to zero and the visit budget to five.
// ----------------------------------------------------------------------------
// Periodic probe scheduler
// Strategy slots with schedule tables and due-sorted object queues, stepped
// by a small sequencer over two RAMs.
// ----------------------------------------------------------------------------
module periodic_probe_scheduler_top #(
  parameter int STRATEGIES  = pps_pkg::STRATEGIES_DEF,
  parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF,
  parameter int SCHEDULES   = pps_pkg::SCHEDULES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // strategy[1:0], item[9:2], period[25:10], timed[26], zeros[31:27]
  input  logic [31:0] s_axis_tdata,
  // op[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_strategy[1:0], out_object[9:2], status[13:10], zeros[15:14]
  output logic [15:0] m_axis_tdata,
  // fired[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);
  import pps_pkg::*;

  `include "periodic_probe_scheduler_top_defines.svh"

  localparam int SIW = (STRATEGIES > 1) ? $clog2(STRATEGIES) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SXW = (SCHEDULES > 1) ? $clog2(SCHEDULES) : 1;
  localparam int QN  = STRATEGIES * QUEUE_DEPTH;
  localparam int QAW = (QN > 1) ? $clog2(QN) : 1;
  localparam int SN  = STRATEGIES * SCHEDULES;
  localparam int SAW = (SN > 1) ? $clog2(SN) : 1;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DISPATCH = 5'd1;
  localparam logic [4:0] ST_QS_RD    = 5'd2;
  localparam logic [4:0] ST_QS_CHK   = 5'd3;
  localparam logic [4:0] ST_QS_DONE  = 5'd4;
  localparam logic [4:0] ST_SH_CHK   = 5'd5;
  localparam logic [4:0] ST_SH_WR    = 5'd6;
  localparam logic [4:0] ST_INS      = 5'd7;
  localparam logic [4:0] ST_DEL_FIN  = 5'd8;
  localparam logic [4:0] ST_SS_RD    = 5'd9;
  localparam logic [4:0] ST_SS_CHK   = 5'd10;
  localparam logic [4:0] ST_SS_DONE  = 5'd11;
  localparam logic [4:0] ST_RS_RD    = 5'd12;
  localparam logic [4:0] ST_RS_CHK   = 5'd13;
  localparam logic [4:0] ST_RS_DONE  = 5'd14;
  localparam logic [4:0] ST_CL_RD    = 5'd15;
  localparam logic [4:0] ST_CL_WR    = 5'd16;
  localparam logic [4:0] ST_T_SLOT   = 5'd17;
  localparam logic [4:0] ST_T_RD     = 5'd18;
  localparam logic [4:0] ST_T_CHK    = 5'd19;
  localparam logic [4:0] ST_T_EMIT   = 5'd20;
  localparam logic [4:0] ST_T_TAIL   = 5'd21;
  localparam logic [4:0] ST_T_NEXT   = 5'd22;
  localparam logic [4:0] ST_T_END    = 5'd23;
  localparam logic [4:0] ST_RESP     = 5'd24;

  // Queue RAM address of entry i in slot s
  function automatic logic [QAW-1:0] qa(logic [SIW-1:0] s, logic [CW-1:0] i);
    return QAW'(s) * QAW'(QUEUE_DEPTH) + QAW'(i);
  endfunction

  // Schedule RAM address of entry i in slot s
  function automatic logic [SAW-1:0] sa(logic [SIW-1:0] s, logic [SXW-1:0] i);
    return SAW'(s) * SAW'(SCHEDULES) + SAW'(i);
  endfunction

  // Control and per-slot state
  logic [4:0]  state_q, state_d;
  logic [4:0]  ret_q, ret_d;
  logic [3:0]  budget_cfg_q, budget_cfg_d;
  logic [31:0] now_q, now_d;

  logic                 svalid_q [STRATEGIES];
  logic                 svalid_d [STRATEGIES];
  logic [16:0]          period_q [STRATEGIES];
  logic [16:0]          period_d [STRATEGIES];
  logic                 active_q [STRATEGIES];
  logic                 active_d [STRATEGIES];
  logic [31:0]          ndue_q   [STRATEGIES];
  logic [31:0]          ndue_d   [STRATEGIES];
  logic [CW-1:0]        qcnt_q   [STRATEGIES];
  logic [CW-1:0]        qcnt_d   [STRATEGIES];
  logic [SCHEDULES-1:0] schv_q   [STRATEGIES];
  logic [SCHEDULES-1:0] schv_d   [STRATEGIES];

  // Current item
  logic [2:0]  op_q, op_d;
  logic [1:0]  sf_q, sf_d;
  logic [7:0]  item_q, item_d;
  logic [15:0] per_q, per_d;
  logic        timed_q, timed_d;
  logic [3:0]  status_q, status_d;
  logic [SIW-1:0] cur_q, cur_d;

  // Walk registers
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  fidx_q, fidx_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic           found_q, found_d;
  logic           posset_q, posset_d;
  logic           up_q, up_d;
  logic [31:0]    nd_q, nd_d;
  logic [31:0]    head0_q, head0_d;
  logic [31:0]    head1_q, head1_d;
  logic [SXW-1:0] sidx_q, sidx_d;
  logic [SXW-1:0] sfnd_q, sfnd_d;
  logic [SXW-1:0] sfree_q, sfree_d;
  logic           freef_q, freef_d;
  logic [16:0]    min_q, min_d;
  logic           anyv_q, anyv_d;
  logic           anyt_q, anyt_d;
  logic [3:0]     budget_q, budget_d;
  logic [7:0]     obj_q, obj_d;

  // Output register
  logic        m_valid_q, m_valid_d;
  logic [1:0]  m_strat_q, m_strat_d;
  logic [7:0]  m_obj_q, m_obj_d;
  logic [3:0]  m_stat_q, m_stat_d;
  logic        m_fired_q, m_fired_d;
  logic        m_last_q, m_last_d;
  logic        out_free;

  // RAM ports
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [39:0]    q_wdata, q_rdata;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [24:0]    s_wdata, s_rdata;

  logic [CW-1:0]  cnt;
  logic [31:0]    rd_due, clamp;
  logic [7:0]     rd_obj;

  // queue entry: object[39:32], due[31:0]
  pps_ram #(.WIDTH(40), .DEPTH(QN)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // schedule entry: timed[24], period[23:8], id[7:0]
  pps_ram #(.WIDTH(25), .DEPTH(SN)) u_sched_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_stat_q, m_obj_q, m_strat_q};
  assign m_axis_tuser  = m_fired_q;
  assign m_axis_tlast  = m_last_q;

  assign out_free = !m_valid_q || m_axis_tready;
  assign cnt      = qcnt_q[cur_q];
  assign rd_due   = q_rdata[31:0];
  assign rd_obj   = q_rdata[39:32];
  assign clamp    = (rd_due > nd_q) ? nd_q : rd_due;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    budget_cfg_d = budget_cfg_q;
    now_d        = now_q;
    svalid_d     = svalid_q;
    period_d     = period_q;
    active_d     = active_q;
    ndue_d       = ndue_q;
    qcnt_d       = qcnt_q;
    schv_d       = schv_q;
    op_d         = op_q;
    sf_d         = sf_q;
    item_d       = item_q;
    per_d        = per_q;
    timed_d      = timed_q;
    status_d     = status_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    fidx_d       = fidx_q;
    pos_d        = pos_q;
    found_d      = found_q;
    posset_d     = posset_q;
    up_d         = up_q;
    nd_d         = nd_q;
    head0_d      = head0_q;
    head1_d      = head1_q;
    sidx_d       = sidx_q;
    sfnd_d       = sfnd_q;
    sfree_d      = sfree_q;
    freef_d      = freef_q;
    min_d        = min_q;
    anyv_d       = anyv_q;
    anyt_d       = anyt_q;
    budget_d     = budget_q;
    obj_d        = obj_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_strat_d    = m_strat_q;
    m_obj_d      = m_obj_q;
    m_stat_d     = m_stat_q;
    m_fired_d    = m_fired_q;
    m_last_d     = m_last_q;
    q_we         = 1'b0;
    q_waddr      = qa(cur_q, idx_q);
    q_wdata      = q_rdata;
    q_raddr      = qa(cur_q, idx_q);
    s_we         = 1'b0;
    s_waddr      = sa(cur_q, sfree_q);
    s_wdata      = {timed_q, per_q, item_q};
    s_raddr      = sa(cur_q, sidx_q);

    if (cfg_valid_i) begin
      budget_cfg_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = s_axis_tuser;
          sf_d     = s_axis_tdata[1:0];
          item_d   = s_axis_tdata[9:2];
          per_d    = s_axis_tdata[25:10];
          timed_d  = s_axis_tdata[26];
          cur_d    = SIW'(s_axis_tdata[1:0]);
          status_d = STAT_OK;
          state_d  = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        if (op_q == OP_TICK) begin
          cur_d   = '0;
          state_d = ST_T_SLOT;
        end else if (32'(sf_q) >= STRATEGIES) begin
          status_d = STAT_STRAT_MISS;
          state_d  = ST_RESP;
        end else if (op_q == OP_ADD_STRAT) begin
          if (svalid_q[cur_q]) begin
            status_d = STAT_STRAT_EXISTS;
          end else begin
            svalid_d[cur_q] = 1'b1;
            period_d[cur_q] = '0;
            active_d[cur_q] = 1'b0;
            ndue_d[cur_q]   = '0;
            qcnt_d[cur_q]   = '0;
            schv_d[cur_q]   = '0;
          end
          state_d = ST_RESP;
        end else if (!svalid_q[cur_q]) begin
          status_d = STAT_STRAT_MISS;
          state_d  = ST_RESP;
        end else if (op_q == OP_DEL_STRAT) begin
          svalid_d[cur_q] = 1'b0;
          period_d[cur_q] = '0;
          active_d[cur_q] = 1'b0;
          ndue_d[cur_q]   = '0;
          qcnt_d[cur_q]   = '0;
          schv_d[cur_q]   = '0;
          state_d         = ST_RESP;
        end else if (op_q == OP_ADD_OBJ || op_q == OP_DEL_OBJ) begin
          idx_d    = '0;
          found_d  = 1'b0;
          posset_d = 1'b0;
          pos_d    = cnt;
          nd_d     = due_from_now(period_q[cur_q], now_q);
          state_d  = (cnt == '0) ? ST_QS_DONE : ST_QS_RD;
        end else begin
          sidx_d  = '0;
          found_d = 1'b0;
          freef_d = 1'b0;
          state_d = ST_SS_RD;
        end
      end

      // Scan the queue: find the object, the insert point and the head dues
      ST_QS_RD: begin
        state_d = ST_QS_CHK;
      end

      ST_QS_CHK: begin
        if (rd_obj == item_q && !found_q) begin
          found_d = 1'b1;
          fidx_d  = idx_q;
        end
        if (rd_due > nd_q && !posset_q) begin
          posset_d = 1'b1;
          pos_d    = idx_q;
        end
        if (idx_q == CW'(0)) begin
          head0_d = rd_due;
        end
        if (idx_q == CW'(1)) begin
          head1_d = rd_due;
        end
        if ((CW + 1)'(idx_q) + 1'b1 < (CW + 1)'(cnt)) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_QS_RD;
        end else begin
          state_d = ST_QS_DONE;
        end
      end

      ST_QS_DONE: begin
        if (op_q == OP_ADD_OBJ) begin
          if (found_q) begin
            status_d = STAT_OBJ_EXISTS;
            state_d  = ST_RESP;
          end else if (32'(cnt) >= QUEUE_DEPTH) begin
            status_d = STAT_QUEUE_FULL;
            state_d  = ST_RESP;
          end else begin
            idx_d   = cnt;
            up_d    = 1'b1;
            ret_d   = ST_INS;
            state_d = ST_SH_CHK;
          end
        end else if (!found_q) begin
          status_d = STAT_OBJ_MISS;
          state_d  = ST_RESP;
        end else begin
          idx_d   = fidx_q;
          up_d    = 1'b0;
          ret_d   = ST_DEL_FIN;
          state_d = ST_SH_CHK;
        end
      end

      // Move entries one by one, up toward the tail or down toward the head
      ST_SH_CHK: begin
        if (up_q) begin
          q_raddr = qa(cur_q, idx_q - 1'b1);
          state_d = (idx_q > pos_q) ? ST_SH_WR : ret_q;
        end else begin
          q_raddr = qa(cur_q, idx_q + 1'b1);
          state_d = ((CW + 1)'(idx_q) + 1'b1 < (CW + 1)'(cnt)) ? ST_SH_WR : ret_q;
        end
      end

      ST_SH_WR: begin
        q_we    = 1'b1;
        q_waddr = qa(cur_q, idx_q);
        q_wdata = q_rdata;
        idx_d   = up_q ? idx_q - 1'b1 : idx_q + 1'b1;
        state_d = ST_SH_CHK;
      end

      ST_INS: begin
        q_we          = 1'b1;
        q_waddr       = qa(cur_q, pos_q);
        q_wdata       = {item_q, nd_q};
        qcnt_d[cur_q] = cnt + 1'b1;
        if (!active_q[cur_q]) begin
          ndue_d[cur_q] = '0;
        end else begin
          ndue_d[cur_q] = (pos_q == '0) ? nd_q : head0_q;
        end
        state_d = ST_RESP;
      end

      ST_DEL_FIN: begin
        qcnt_d[cur_q] = cnt - 1'b1;
        if (cnt == CW'(1) || !active_q[cur_q]) begin
          ndue_d[cur_q] = '0;
        end else begin
          ndue_d[cur_q] = (fidx_q == '0) ? head1_q : head0_q;
        end
        state_d = ST_RESP;
      end

      // Scan the schedule table for the id and the first free entry
      ST_SS_RD: begin
        state_d = ST_SS_CHK;
      end

      ST_SS_CHK: begin
        if (schv_q[cur_q][sidx_q] && s_rdata[7:0] == item_q && !found_q) begin
          found_d = 1'b1;
          sfnd_d  = sidx_q;
        end
        if (!schv_q[cur_q][sidx_q] && !freef_q) begin
          freef_d = 1'b1;
          sfree_d = sidx_q;
        end
        if (sidx_q == SXW'(SCHEDULES - 1)) begin
          state_d = ST_SS_DONE;
        end else begin
          sidx_d  = sidx_q + 1'b1;
          state_d = ST_SS_RD;
        end
      end

      ST_SS_DONE: begin
        sidx_d = '0;
        min_d  = UNTIMED_PERIOD;
        anyv_d = 1'b0;
        anyt_d = 1'b0;
        state_d = ST_RS_RD;
        if (op_q == OP_ADD_SCHED) begin
          if (found_q) begin
            status_d = STAT_SCHED_EXISTS;
            state_d  = ST_RESP;
          end else if (!freef_q) begin
            status_d = STAT_SCHED_FULL;
            state_d  = ST_RESP;
          end else begin
            s_we                   = 1'b1;
            s_waddr                = sa(cur_q, sfree_q);
            schv_d[cur_q][sfree_q] = 1'b1;
          end
        end else if (!found_q) begin
          status_d = STAT_SCHED_MISS;
          state_d  = ST_RESP;
        end else if (op_q == OP_MOD_SCHED) begin
          s_we    = 1'b1;
          s_waddr = sa(cur_q, sfnd_q);
        end else begin
          schv_d[cur_q][sfnd_q] = 1'b0;
        end
      end

      // Recompute the slot period as the least timed period (untimed if none is timed, zero if the table is empty)
      ST_RS_RD: begin
        state_d = ST_RS_CHK;
      end

      ST_RS_CHK: begin
        if (schv_q[cur_q][sidx_q]) begin
          anyv_d = 1'b1;
          if (s_rdata[24]) begin
            anyt_d = 1'b1;
            if ({1'b0, s_rdata[23:8]} < min_q) begin
              min_d = {1'b0, s_rdata[23:8]};
            end
          end
        end
        if (sidx_q == SXW'(SCHEDULES - 1)) begin
          state_d = ST_RS_DONE;
        end else begin
          sidx_d  = sidx_q + 1'b1;
          state_d = ST_RS_RD;
        end
      end

      ST_RS_DONE: begin
        state_d = ST_RESP;
        if (!anyv_q) begin
          period_d[cur_q] = '0;
          active_d[cur_q] = 1'b0;
        end else begin
          period_d[cur_q] = min_q;
          active_d[cur_q] = anyt_q;
          if (anyt_q && cnt != '0) begin
            nd_d    = due_from_now(min_q, now_q);
            idx_d   = '0;
            state_d = ST_CL_RD;
          end
        end
      end

      // Clamp every queued due time to the new limit
      ST_CL_RD: begin
        state_d = ST_CL_WR;
      end

      ST_CL_WR: begin
        q_we    = 1'b1;
        q_waddr = qa(cur_q, idx_q);
        q_wdata = {rd_obj, clamp};
        if (idx_q == '0) begin
          ndue_d[cur_q] = clamp;
        end
        if ((CW + 1)'(idx_q) + 1'b1 < (CW + 1)'(cnt)) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CL_RD;
        end else begin
          state_d = ST_RESP;
        end
      end

      // Tick: visit each due active slot in order
      ST_T_SLOT: begin
        if (!svalid_q[cur_q] || !active_q[cur_q] || now_q < ndue_q[cur_q]) begin
          state_d = ST_T_NEXT;
        end else if (cnt == '0) begin
          ndue_d[cur_q] = due_from_now(period_q[cur_q], now_q);
          state_d       = ST_T_NEXT;
        end else begin
          budget_d = budget_cfg_q;
          state_d  = ST_T_RD;
        end
      end

      ST_T_RD: begin
        q_raddr = qa(cur_q, '0);
        state_d = ST_T_CHK;
      end

      ST_T_CHK: begin
        if (budget_q == '0 || rd_due > now_q) begin
          ndue_d[cur_q] = rd_due;
          state_d       = ST_T_NEXT;
        end else begin
          obj_d   = rd_obj;
          state_d = ST_T_EMIT;
        end
      end

      ST_T_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_strat_d = 2'(cur_q);
          m_obj_d   = obj_q;
          m_stat_d  = STAT_OK;
          m_fired_d = 1'b1;
          m_last_d  = 1'b0;
          idx_d     = '0;
          up_d      = 1'b0;
          ret_d     = ST_T_TAIL;
          state_d   = ST_SH_CHK;
        end
      end

      // Requeue the fired head at the tail
      ST_T_TAIL: begin
        q_we     = 1'b1;
        q_waddr  = qa(cur_q, cnt - 1'b1);
        q_wdata  = {obj_q, due_from_now(period_q[cur_q], now_q)};
        budget_d = budget_q - 1'b1;
        state_d  = ST_T_RD;
      end

      ST_T_NEXT: begin
        if (32'(cur_q) == STRATEGIES - 1) begin
          state_d = ST_T_END;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = ST_T_SLOT;
        end
      end

      ST_T_END: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_strat_d = '0;
          m_obj_d   = '0;
          m_stat_d  = STAT_OK;
          m_fired_d = 1'b0;
          m_last_d  = 1'b1;
          if (now_q != TIME_MAX) begin
            now_d = now_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_strat_d = sf_q;
          m_obj_d   = item_q;
          m_stat_d  = status_q;
          m_fired_d = 1'b0;
          m_last_d  = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      budget_cfg_q <= BUDGET_RESET;
      now_q        <= '0;
      m_valid_q    <= 1'b0;
      for (int i = 0; i < STRATEGIES; i++) begin
        svalid_q[i] <= 1'b0;
        period_q[i] <= '0;
        active_q[i] <= 1'b0;
        ndue_q[i]   <= '0;
        qcnt_q[i]   <= '0;
        schv_q[i]   <= '0;
      end
    end else begin
      state_q      <= state_d;
      budget_cfg_q <= budget_cfg_d;
      now_q        <= now_d;
      m_valid_q    <= m_valid_d;
      svalid_q     <= svalid_d;
      period_q     <= period_d;
      active_q     <= active_d;
      ndue_q       <= ndue_d;
      qcnt_q       <= qcnt_d;
      schv_q       <= schv_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    op_q      <= op_d;
    sf_q      <= sf_d;
    item_q    <= item_d;
    per_q     <= per_d;
    timed_q   <= timed_d;
    status_q  <= status_d;
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    fidx_q    <= fidx_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
    posset_q  <= posset_d;
    up_q      <= up_d;
    nd_q      <= nd_d;
    head0_q   <= head0_d;
    head1_q   <= head1_d;
    sidx_q    <= sidx_d;
    sfnd_q    <= sfnd_d;
    sfree_q   <= sfree_d;
    freef_q   <= freef_d;
    min_q     <= min_d;
    anyv_q    <= anyv_d;
    anyt_q    <= anyt_d;
    budget_q  <= budget_d;
    obj_q     <= obj_d;
    m_strat_q <= m_strat_d;
    m_obj_q   <= m_obj_d;
    m_stat_q  <= m_stat_d;
    m_fired_q <= m_fired_d;
    m_last_q  <= m_last_d;
  end

  // Time moves only when a tick closes
  `PPS_ASSERT_NEXT(a_now_hold, !(state_q == ST_T_END && out_free), $stable(now_q), "now changed outside tick close")
  // An accepted item is decoded in the next cycle
  `PPS_ASSERT_NEXT(a_accept_dispatch, s_axis_tvalid && s_axis_tready, state_q == ST_DISPATCH, "accepted item not dispatched")
  // A closing result returns the sequencer to idle
  `PPS_ASSERT_NEXT(a_last_idle, state_q == ST_RESP && out_free, state_q == ST_IDLE && m_axis_tlast, "closing result did not end the item")
  // No queue or schedule RAM write happens while idle
  `PPS_ASSERT_SAME(a_idle_quiet, state_q == ST_IDLE, !q_we && !s_we, "RAM write while idle")

endmodule
